[design/heightmap_grid_mesh_builder_macros.svh]
// Assertion macros for the heightmap grid mesh builder.
// Used by the top level; needs clk and arst_n in scope where expanded.
`ifndef HEIGHTMAP_GRID_MESH_BUILDER_MACROS_SVH
`define HEIGHTMAP_GRID_MESH_BUILDER_MACROS_SVH

// same-cycle implication, quiet during reset
`define HGMB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define HGMB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hgmb_pkg.sv]
// Types and constants for the heightmap grid mesh builder.
// No dependencies; used by heightmap_grid_mesh_builder.
package hgmb_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FETCH,
		ST_TEXU_SET,
		ST_TEXV_SET,
		ST_DIV,
		ST_TRI_NEXT,
		ST_SQ,
		ST_MSQ,
		ST_DIV_SET,
		ST_SQRT_SET,
		ST_SQRT,
		ST_COMP,
		ST_NORM_END,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		JOB_TEXU,
		JOB_TEXV,
		JOB_NORM
	} job_t;

	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_VERTEX   = 2'd1;
	localparam logic [1:0] ACT_TRIANGLE = 2'd2;
	localparam logic [1:0] ACT_NONE     = 2'd3;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_SPACING = 2'd2;
	localparam logic [1:0] REG_SPARE   = 2'd3;

	localparam logic [8:0]  COLUMNS_RST = 9'd129;
	localparam logic [8:0]  ROWS_RST    = 9'd129;
	localparam logic [15:0] SPACING_RST = 16'd256;

	localparam logic [8:0] SIDE_MIN = 9'd2;
	localparam logic [8:0] SIDE_MAX = 9'd256;
	localparam int         MEM_DEPTH = 65536;

	// x/10 == (x*RECIP10)>>19 for every 16-bit x
	localparam logic [16:0] RECIP10 = 17'd52429;
	localparam logic [21:0] TEX_SCALE = 22'd10240;

	localparam logic [4:0] NORM_ITER = 5'd31;
	localparam logic [4:0] TEX_ITER  = 5'd22;
	localparam logic [4:0] SQRT_ITER = 5'd16;
	localparam logic [4:0] FETCH_LAST = 5'd9;
	localparam logic [4:0] SQ_LAST   = 5'd3;
	localparam logic [2:0] TRI_COUNT = 3'd6;

endpackage

[design/heightmap_grid_mesh_builder.sv]
// Heightmap grid mesh builder: height store, vertex and triangle queries.
// Depends on hgmb_pkg and heightmap_grid_mesh_builder_macros.svh.
//
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries action, column, row, half and
//   height_sample. A word is taken when cmd_valid is high and cmd_stall low.
//   A load writes the height store if column and row lie inside the grid and
//   gives no result; the block stays ready. Action 3 is dropped the same way.
//   Result channel (res_valid/res_stall) carries one word per vertex or
//   triangle query. A finished word sits in the output register while the
//   command side is ready again; it holds while res_stall is high.
//   Triangle and out-of-range queries skip the fetch and go from evaluation straight to the output register.
//   A vertex query reads nine heights (one store read port), runs two texture
//   divisions (22 steps each) and up to seven normalisations on one shared
//   subtract-and-compare unit: per normalisation three passes, each a 31-step
//   division and a 16-step square root; the number of normalisations
//   depends on how many triangles touch the vertex.
//   Configuration goes through the APB port at 0 (columns), 4 (rows) and
//   8 (spacing); the user writes it only while idle, the block does not enforce this.
//   Reset (arst_n low) returns registers to 129, 129, 256 and empties the
//   output; the height store is not cleared and reads undefined until written.
`include "heightmap_grid_mesh_builder_macros.svh"

module heightmap_grid_mesh_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic        half,
	input  logic [7:0]  height_sample,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [23:0] pos_x,
	output logic [12:0] pos_y,
	output logic [23:0] pos_z,
	output logic [12:0] tex_u,
	output logic [12:0] tex_v,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [15:0] corner_a,
	output logic [15:0] corner_b,
	output logic [15:0] corner_c,
	output logic        out_of_range
);

	hgmb_pkg::state_t state_q, state_d;

	logic [8:0]  cols_q, rows_q;
	logic [15:0] spacing_q;
	logic [8:0]  cols_eff, rows_eff;
	logic        cfg_wr;

	logic        cmd_accept, mem_we, mem_in_grid;
	logic [15:0] rd_addr;
	logic [7:0]  rdata_q;
	logic [7:0]  hmem [hgmb_pkg::MEM_DEPTH];

	logic [1:0]  act_q;
	logic [7:0]  col_q, row_q;
	logic        half_q;
	logic [7:0]  g_q [9];

	logic [4:0]  cnt_q;
	logic [2:0]  tri_q;
	logic [1:0]  comp_q;
	logic        final_q;
	hgmb_pkg::job_t job_q;

	logic [39:0] s_q, prod_q, rem_q, div_q;
	logic [31:0] dvd_q;
	logic [30:0] quot_q;
	logic [15:0] root_q;
	logic signed [15:0] u_q [3];
	logic signed [17:0] acc_q [3];

	logic [23:0] rpx_q, rpz_q;
	logic [12:0] rpy_q, rtu_q, rtv_q;
	logic [15:0] rca_q, rcb_q, rcc_q;
	logic        roor_q;

	logic        res_valid_q, out_load;
	logic [23:0] pos_x_q, pos_z_q;
	logic [12:0] pos_y_q, tex_u_q, tex_v_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic [15:0] ca_q, cb_q, cc_q;
	logic        oor_q;

	// ---------------------------------------------------------------
	// combinational helpers
	// ---------------------------------------------------------------
	function automatic logic signed [20:0] hdiff(input logic [7:0] a, input logic [7:0] b);
		logic signed [8:0] dd;
		dd = $signed({1'b0, a}) - $signed({1'b0, b});
		return {{4{dd[8]}}, dd, 8'b0};
	endfunction

	logic        c1ok, r1ok, c0ok, r0ok, eval_oor, tri_en, en_sel;
	logic [19:0] d20;
	logic signed [20:0] tx, tz;
	logic signed [20:0] vec [3];
	logic [19:0] mag [3];
	logic [1:0]  mul_sel;
	logic [39:0] sq;
	logic [39:0] s_sum;
	logic [40:0] sub_a, sub_b;
	logic [41:0] diff;
	logic        ge;
	logic [1:0]  fi, fj;
	logic [7:0]  f_row, f_col;
	logic [16:0] base;
	logic [21:0] nu, nv;
	logic [32:0] py_prod;
	logic [16:0] lo_sum;
	logic [15:0] lo;

	always_comb begin
		cols_eff = cols_q;
		if (cols_q < hgmb_pkg::SIDE_MIN) cols_eff = hgmb_pkg::SIDE_MIN;
		if (cols_q > hgmb_pkg::SIDE_MAX) cols_eff = hgmb_pkg::SIDE_MAX;
		rows_eff = rows_q;
		if (rows_q < hgmb_pkg::SIDE_MIN) rows_eff = hgmb_pkg::SIDE_MIN;
		if (rows_q > hgmb_pkg::SIDE_MAX) rows_eff = hgmb_pkg::SIDE_MAX;
	end

	assign c1ok = ({1'b0, col_q} + 9'd1) < cols_eff;
	assign r1ok = ({1'b0, row_q} + 9'd1) < rows_eff;
	assign c0ok = (col_q != 8'd0);
	assign r0ok = (row_q != 8'd0);
	assign d20  = ({4'b0, spacing_q} << 3) + ({4'b0, spacing_q} << 1);

	always_comb begin
		if (act_q == hgmb_pkg::ACT_TRIANGLE)
			eval_oor = !c1ok || !r1ok;
		else
			eval_oor = ({1'b0, col_q} >= cols_eff) || ({1'b0, row_q} >= rows_eff);
	end

	// triangles around the vertex; g index is row offset*3 + column offset
	always_comb begin
		tx = '0;
		tz = '0;
		en_sel = 1'b0;
		case (tri_q)
			3'd0: begin
				tx = hdiff(g_q[4], g_q[5]); tz = hdiff(g_q[4], g_q[7]); en_sel = c1ok && r1ok;
			end
			3'd1: begin
				tx = hdiff(g_q[6], g_q[7]); tz = hdiff(g_q[4], g_q[7]); en_sel = c0ok && r1ok;
			end
			3'd2: begin
				tx = hdiff(g_q[3], g_q[4]); tz = hdiff(g_q[3], g_q[6]); en_sel = c0ok && r1ok;
			end
			3'd3: begin
				tx = hdiff(g_q[4], g_q[5]); tz = hdiff(g_q[2], g_q[5]); en_sel = c1ok && r0ok;
			end
			3'd4: begin
				tx = hdiff(g_q[1], g_q[2]); tz = hdiff(g_q[1], g_q[4]); en_sel = c1ok && r0ok;
			end
			3'd5: begin
				tx = hdiff(g_q[3], g_q[4]); tz = hdiff(g_q[1], g_q[4]); en_sel = c0ok && r0ok;
			end
			default: begin
				tx = '0; tz = '0; en_sel = 1'b0;
			end
		endcase
	end

	assign tri_en = en_sel && (d20 != 20'd0);

	always_comb begin
		if (final_q) begin
			vec[0] = {{3{acc_q[0][17]}}, acc_q[0]};
			vec[1] = {{3{acc_q[1][17]}}, acc_q[1]};
			vec[2] = {{3{acc_q[2][17]}}, acc_q[2]};
		end else begin
			vec[0] = tx;
			vec[1] = $signed({1'b0, d20});
			vec[2] = tz;
		end
		for (int k = 0; k < 3; k++)
			mag[k] = vec[k][20] ? 20'(-vec[k]) : vec[k][19:0];
	end

	// shared squarer
	assign sq    = {20'b0, mag[mul_sel]} * {20'b0, mag[mul_sel]};
	assign s_sum = s_q + prod_q;

	// shared subtract-and-compare unit: division and square root steps
	always_comb begin
		if (state_q == hgmb_pkg::ST_SQRT) begin
			sub_a = {rem_q, dvd_q[31:30]}[40:0];
			sub_b = {23'b0, root_q, 2'b01};
		end else begin
			sub_a = {rem_q, dvd_q[31]};
			sub_b = {1'b0, div_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
	end
	assign ge = !diff[41];

	assign lo_sum = {1'b0, root_q} + 17'd1;
	assign lo     = lo_sum[16:1];

	assign base    = {9'b0, row_q} * {8'b0, cols_eff} + {9'b0, col_q};
	assign nu      = {14'b0, col_q} * hgmb_pkg::TEX_SCALE + {13'b0, cols_eff - 9'd1};
	assign nv      = {14'b0, row_q} * hgmb_pkg::TEX_SCALE + {13'b0, rows_eff - 9'd1};
	assign py_prod = {17'b0, g_q[4], 8'h05} * {16'b0, hgmb_pkg::RECIP10};

	// ---------------------------------------------------------------
	// sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hgmb_pkg::ST_IDLE: begin
				if (cmd_accept && (action == hgmb_pkg::ACT_VERTEX ||
						action == hgmb_pkg::ACT_TRIANGLE))
					state_d = hgmb_pkg::ST_EVAL;
			end
			hgmb_pkg::ST_EVAL: begin
				if (eval_oor || act_q == hgmb_pkg::ACT_TRIANGLE)
					state_d = hgmb_pkg::ST_DONE;
				else
					state_d = hgmb_pkg::ST_FETCH;
			end
			hgmb_pkg::ST_FETCH: begin
				if (cnt_q == hgmb_pkg::FETCH_LAST) state_d = hgmb_pkg::ST_TEXU_SET;
			end
			hgmb_pkg::ST_TEXU_SET: state_d = hgmb_pkg::ST_DIV;
			hgmb_pkg::ST_TEXV_SET: state_d = hgmb_pkg::ST_DIV;
			hgmb_pkg::ST_DIV: begin
				if (cnt_q == 5'd1) begin
					unique case (job_q)
						hgmb_pkg::JOB_TEXU: state_d = hgmb_pkg::ST_TEXV_SET;
						hgmb_pkg::JOB_TEXV: state_d = hgmb_pkg::ST_TRI_NEXT;
						default:            state_d = hgmb_pkg::ST_SQRT_SET;
					endcase
				end
			end
			hgmb_pkg::ST_TRI_NEXT: begin
				if (tri_q == hgmb_pkg::TRI_COUNT || tri_en) state_d = hgmb_pkg::ST_SQ;
			end
			hgmb_pkg::ST_SQ: begin
				if (cnt_q == hgmb_pkg::SQ_LAST)
					state_d = (s_sum == 40'd0) ? hgmb_pkg::ST_NORM_END : hgmb_pkg::ST_MSQ;
			end
			hgmb_pkg::ST_MSQ:      state_d = hgmb_pkg::ST_DIV_SET;
			hgmb_pkg::ST_DIV_SET:  state_d = hgmb_pkg::ST_DIV;
			hgmb_pkg::ST_SQRT_SET: state_d = hgmb_pkg::ST_SQRT;
			hgmb_pkg::ST_SQRT: begin
				if (cnt_q == 5'd1) state_d = hgmb_pkg::ST_COMP;
			end
			hgmb_pkg::ST_COMP: begin
				state_d = (comp_q == 2'd2) ? hgmb_pkg::ST_NORM_END : hgmb_pkg::ST_MSQ;
			end
			hgmb_pkg::ST_NORM_END: begin
				state_d = final_q ? hgmb_pkg::ST_DONE : hgmb_pkg::ST_TRI_NEXT;
			end
			hgmb_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) state_d = hgmb_pkg::ST_IDLE;
			end
			default: state_d = hgmb_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer: control outputs
	// ---------------------------------------------------------------
	always_comb begin
		cmd_stall   = (state_q != hgmb_pkg::ST_IDLE);
		cmd_accept  = cmd_valid && (state_q == hgmb_pkg::ST_IDLE);
		mem_in_grid = ({1'b0, column} < cols_eff) && ({1'b0, row} < rows_eff);
		mem_we      = cmd_accept && (action == hgmb_pkg::ACT_LOAD) && mem_in_grid;
		out_load    = (state_q == hgmb_pkg::ST_DONE) && (!res_valid_q || !res_stall);
		mul_sel     = (state_q == hgmb_pkg::ST_SQ) ? cnt_q[1:0] : comp_q;
		if (mul_sel == 2'd3) mul_sel = 2'd0;
		fi = 2'd0;
		fj = 2'd0;
		unique case (cnt_q[3:0])
			4'd0: begin fi = 2'd0; fj = 2'd0; end
			4'd1: begin fi = 2'd0; fj = 2'd1; end
			4'd2: begin fi = 2'd0; fj = 2'd2; end
			4'd3: begin fi = 2'd1; fj = 2'd0; end
			4'd4: begin fi = 2'd1; fj = 2'd1; end
			4'd5: begin fi = 2'd1; fj = 2'd2; end
			4'd6: begin fi = 2'd2; fj = 2'd0; end
			4'd7: begin fi = 2'd2; fj = 2'd1; end
			4'd8: begin fi = 2'd2; fj = 2'd2; end
			default: begin fi = 2'd1; fj = 2'd1; end
		endcase
		f_row   = row_q + {6'b0, fi} - 8'd1;
		f_col   = col_q + {6'b0, fj} - 8'd1;
		rd_addr = {f_row, f_col};
	end

	// ---------------------------------------------------------------
	// height store
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) hmem[{row, column}] <= height_sample;
		rdata_q <= hmem[rd_addr];
	end

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			hgmb_pkg::REG_COLUMNS: prdata = {23'b0, cols_q};
			hgmb_pkg::REG_ROWS:    prdata = {23'b0, rows_q};
			hgmb_pkg::REG_SPACING: prdata = {16'b0, spacing_q};
			default:               prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hgmb_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			cols_q      <= hgmb_pkg::COLUMNS_RST;
			rows_q      <= hgmb_pkg::ROWS_RST;
			spacing_q   <= hgmb_pkg::SPACING_RST;
		end else begin
			state_q <= state_d;
			if (out_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					hgmb_pkg::REG_COLUMNS: cols_q    <= pwdata[8:0];
					hgmb_pkg::REG_ROWS:    rows_q    <= pwdata[8:0];
					hgmb_pkg::REG_SPACING: spacing_q <= pwdata[15:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// datapath
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			hgmb_pkg::ST_IDLE: begin
				if (cmd_accept) begin
					act_q  <= action;
					col_q  <= column;
					row_q  <= row;
					half_q <= half;
				end
			end
			hgmb_pkg::ST_EVAL: begin
				rpx_q  <= '0; rpy_q <= '0; rpz_q <= '0; rtu_q <= '0; rtv_q <= '0;
				rca_q  <= '0; rcb_q <= '0; rcc_q <= '0;
				roor_q <= eval_oor;
				for (int k = 0; k < 3; k++) begin
					u_q[k]   <= '0;
					acc_q[k] <= '0;
				end
				tri_q   <= '0;
				final_q <= 1'b0;
				cnt_q   <= '0;
				if (!eval_oor) begin
					if (act_q == hgmb_pkg::ACT_TRIANGLE) begin
						rca_q <= base[15:0] + {7'b0, cols_eff};
						if (!half_q) begin
							rcb_q <= base[15:0] + {7'b0, cols_eff} + 16'd1;
							rcc_q <= base[15:0] + 16'd1;
						end else begin
							rcb_q <= base[15:0] + 16'd1;
							rcc_q <= base[15:0];
						end
					end else begin
						rpx_q <= {16'b0, col_q} * {8'b0, spacing_q};
						rpz_q <= {16'b0, row_q} * {8'b0, spacing_q};
					end
				end
			end
			hgmb_pkg::ST_FETCH: begin
				// read data arrives the cycle after its address
				if (cnt_q != 5'd0) g_q[cnt_q[3:0] - 4'd1] <= rdata_q;
				cnt_q <= cnt_q + 5'd1;
			end
			hgmb_pkg::ST_TEXU_SET: begin
				rpy_q  <= py_prod[31:19];
				rem_q  <= '0;
				dvd_q  <= {nu, 10'b0};
				div_q  <= {30'b0, cols_eff - 9'd1, 1'b0};
				quot_q <= '0;
				cnt_q  <= hgmb_pkg::TEX_ITER;
				job_q  <= hgmb_pkg::JOB_TEXU;
			end
			hgmb_pkg::ST_TEXV_SET: begin
				rtu_q  <= quot_q[12:0];
				rem_q  <= '0;
				dvd_q  <= {nv, 10'b0};
				div_q  <= {30'b0, rows_eff - 9'd1, 1'b0};
				quot_q <= '0;
				cnt_q  <= hgmb_pkg::TEX_ITER;
				job_q  <= hgmb_pkg::JOB_TEXV;
			end
			hgmb_pkg::ST_DIV: begin
				rem_q  <= ge ? diff[39:0] : sub_a[39:0];
				dvd_q  <= {dvd_q[30:0], 1'b0};
				quot_q <= {quot_q[29:0], ge};
				cnt_q  <= cnt_q - 5'd1;
			end
			hgmb_pkg::ST_TRI_NEXT: begin
				if (job_q == hgmb_pkg::JOB_TEXV) rtv_q <= quot_q[12:0];
				cnt_q  <= '0;
				prod_q <= '0;
				s_q    <= '0;
				if (tri_q == hgmb_pkg::TRI_COUNT)
					final_q <= 1'b1;
				else if (!tri_en)
					tri_q <= tri_q + 3'd1;
			end
			hgmb_pkg::ST_SQ: begin
				prod_q <= (cnt_q == hgmb_pkg::SQ_LAST) ? 40'd0 : sq;
				s_q    <= s_sum;
				cnt_q  <= cnt_q + 5'd1;
				comp_q <= '0;
				if (cnt_q == hgmb_pkg::SQ_LAST && s_sum == 40'd0) begin
					for (int k = 0; k < 3; k++) u_q[k] <= '0;
				end
			end
			hgmb_pkg::ST_MSQ: begin
				prod_q <= sq;
			end
			hgmb_pkg::ST_DIV_SET: begin
				// quotient 2^30*m^2/s stays below 2^31
				rem_q  <= {1'b0, prod_q[39:1]};
				dvd_q  <= {prod_q[0], 31'b0};
				div_q  <= s_q;
				quot_q <= '0;
				cnt_q  <= hgmb_pkg::NORM_ITER;
				job_q  <= hgmb_pkg::JOB_NORM;
			end
			hgmb_pkg::ST_SQRT_SET: begin
				dvd_q  <= {1'b0, quot_q};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= hgmb_pkg::SQRT_ITER;
			end
			hgmb_pkg::ST_SQRT: begin
				rem_q  <= ge ? diff[39:0] : sub_a[39:0];
				root_q <= {root_q[14:0], ge};
				dvd_q  <= {dvd_q[29:0], 2'b00};
				cnt_q  <= cnt_q - 5'd1;
			end
			hgmb_pkg::ST_COMP: begin
				u_q[comp_q] <= vec[comp_q][20] ? $signed(16'(-lo)) : $signed(lo);
				comp_q      <= comp_q + 2'd1;
			end
			hgmb_pkg::ST_NORM_END: begin
				if (!final_q) begin
					for (int k = 0; k < 3; k++)
						acc_q[k] <= acc_q[k] + {{2{u_q[k][15]}}, u_q[k]};
					tri_q <= tri_q + 3'd1;
				end
			end
			hgmb_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q <= rpx_q;
			pos_y_q <= rpy_q;
			pos_z_q <= rpz_q;
			tex_u_q <= rtu_q;
			tex_v_q <= rtv_q;
			nx_q    <= u_q[0];
			ny_q    <= u_q[1];
			nz_q    <= u_q[2];
			ca_q    <= rca_q;
			cb_q    <= rcb_q;
			cc_q    <= rcc_q;
			oor_q   <= roor_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;
	assign normal_x     = nx_q;
	assign normal_y     = ny_q;
	assign normal_z     = nz_q;
	assign corner_a     = ca_q;
	assign corner_b     = cb_q;
	assign corner_c     = cc_q;
	assign out_of_range = oor_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`HGMB_ASSERT_NXT(a_query_busy, cmd_valid && !cmd_stall && (action == hgmb_pkg::ACT_VERTEX || action == hgmb_pkg::ACT_TRIANGLE), cmd_stall, "query accepted but block still ready")
	`HGMB_ASSERT_IMP(a_div_rem, state_q == hgmb_pkg::ST_DIV, rem_q < div_q, "partial remainder not below divisor")
	`HGMB_ASSERT_IMP(a_norm_range, res_valid, (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384) && (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384) && (normal_z <= 16'sd16384) && (normal_z >= -16'sd16384), "normal component out of unit range")

endmodule
